// ----- sv/srlt_pkg.sv -----
package srlt_pkg;

   // default table capacity
   localparam int TABLE_ENTRIES_DEF = 256;

   // payload widths fixed by the item format
   localparam int INFO_W      = 8;
   localparam int ADDR_W      = 64;
   localparam int INDEX_OUT_W = 8;
   localparam int TOTAL_OUT_W = 9;

   // info byte of a global function symbol
   localparam logic [INFO_W-1:0] FUNC_SYMBOL_INFO = 8'd18;

   // status flags that travel with an item through the cell chain
   typedef struct packed {
      logic valid;
      logic lookup;
      logic found;
      logic stored;
      logic full;
   } token_stat_type;

endpackage

// ----- sv/srlt_req_if.sv -----
interface srlt_req_if;
   import srlt_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [INFO_W-1:0] symbol_info;
   logic [ADDR_W-1:0] address;
   logic [ADDR_W-1:0] symbol_size;

   modport source (output valid, mode, symbol_info, address, symbol_size, input ready);
   modport sink   (input valid, mode, symbol_info, address, symbol_size, output ready);

endinterface

// ----- sv/srlt_rsp_if.sv -----
interface srlt_rsp_if;
   import srlt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [INDEX_OUT_W-1:0] match_index;
   logic                   stored;
   logic                   table_full;
   logic [TOTAL_OUT_W-1:0] entry_total;

   modport source (output valid, found, match_index, stored, table_full, entry_total,
                   input ready);
   modport sink   (input valid, found, match_index, stored, table_full, entry_total,
                   output ready);

endinterface

// ----- sv/srlt_cell.sv -----
module srlt_cell #(
   parameter int TABLE_ENTRIES = srlt_pkg::TABLE_ENTRIES_DEF,
   parameter int CELL_ID       = 0,
   localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   // entry write
   input  logic                          wr_req,
   input  logic [IDX_W-1:0]              wr_slot,
   input  logic [srlt_pkg::ADDR_W-1:0]   wr_start,
   input  logic [srlt_pkg::ADDR_W-1:0]   wr_length,
   // token from the previous cell
   input  srlt_pkg::token_stat_type      in_stat,
   input  logic [srlt_pkg::ADDR_W-1:0]   in_addr,
   input  logic [CNT_W-1:0]              in_total,
   input  logic [IDX_W-1:0]              in_idx,
   // token to the next cell
   output srlt_pkg::token_stat_type      out_stat,
   output logic [srlt_pkg::ADDR_W-1:0]   out_addr,
   output logic [CNT_W-1:0]              out_total,
   output logic [IDX_W-1:0]              out_idx
);
   import srlt_pkg::*;

   logic [ADDR_W-1:0] start_ff;
   logic [ADDR_W-1:0] length_ff;
   token_stat_type    stat_ff, stat_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [CNT_W-1:0]  total_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] offset;
   logic              in_range;
   logic              hit;

   // entry storage, written once when its slot comes up
   always_ff @(posedge clock) begin
      if (wr_req && (wr_slot == IDX_W'(CELL_ID))) begin
         start_ff  <= wr_start;
         length_ff <= wr_length;
      end
   end

   // range check, end taken without wrap
   always_comb begin
      offset   = in_addr - start_ff;
      in_range = (start_ff <= in_addr) && (offset < length_ff);
      hit      = in_stat.valid && in_stat.lookup && !in_stat.found &&
                 (CNT_W'(CELL_ID) < in_total) && in_range;
      stat_in       = in_stat;
      stat_in.found = in_stat.found | hit;
      idx_in        = hit ? IDX_W'(CELL_ID) : in_idx;
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else if (advance) begin
         stat_ff <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addr_ff  <= in_addr;
         total_ff <= in_total;
         idx_ff   <= idx_in;
      end
   end

   assign out_stat  = stat_ff;
   assign out_addr  = addr_ff;
   assign out_total = total_ff;
   assign out_idx   = idx_ff;

endmodule

// ----- sv/symbol_range_lookup_table.sv -----
// throughput: one item per cycle while rsp is not stalled, inserts and lookups mixed freely
// every item walks a chain of TABLE_ENTRIES cells, one cell and one entry per cycle
// a stalled rsp holds the whole chain and deasserts req ready
// reset clears the entry count and the token valid bits
// entry contents are undefined until written
module symbol_range_lookup_table #(
   parameter int TABLE_ENTRIES = srlt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   srlt_req_if.sink   req_chan,
   srlt_rsp_if.source rsp_chan
);
   import srlt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [CNT_W-1:0] held_ff, held_in;
   logic             advance;
   logic             req_xfer;
   logic             is_func;
   logic             has_room;

   token_stat_type    chain_stat  [TABLE_ENTRIES+1];
   logic [ADDR_W-1:0] chain_addr  [TABLE_ENTRIES+1];
   logic [CNT_W-1:0]  chain_total [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]  chain_idx   [TABLE_ENTRIES+1];

   // chain moves whenever the last stage is empty or being drained
   assign advance        = !chain_stat[TABLE_ENTRIES].valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign req_xfer       = req_chan.valid && advance;

   // incoming token
   always_comb begin
      is_func  = (req_chan.mode == 1'b0) && (req_chan.symbol_info == FUNC_SYMBOL_INFO);
      has_room = (held_ff != CNT_W'(TABLE_ENTRIES));
      chain_stat[0].valid  = req_chan.valid;
      chain_stat[0].lookup = req_chan.mode;
      chain_stat[0].found  = 1'b0;
      chain_stat[0].stored = is_func && has_room;
      chain_stat[0].full   = is_func && !has_room;
      chain_addr[0]        = req_chan.address;
      chain_idx[0]         = '0;
      chain_total[0]       = held_ff + CNT_W'(is_func && has_room);
      held_in              = req_xfer ? chain_total[0] : held_ff;
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // one cell per table entry
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      srlt_cell #(
         .TABLE_ENTRIES (TABLE_ENTRIES),
         .CELL_ID       (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .wr_req    (req_xfer && chain_stat[0].stored),
         .wr_slot   (held_ff[IDX_W-1:0]),
         .wr_start  (req_chan.address),
         .wr_length (req_chan.symbol_size),
         .in_stat   (chain_stat[i]),
         .in_addr   (chain_addr[i]),
         .in_total  (chain_total[i]),
         .in_idx    (chain_idx[i]),
         .out_stat  (chain_stat[i+1]),
         .out_addr  (chain_addr[i+1]),
         .out_total (chain_total[i+1]),
         .out_idx   (chain_idx[i+1])
      );
   end

   // result from the last cell
   assign rsp_chan.valid       = chain_stat[TABLE_ENTRIES].valid;
   assign rsp_chan.found       = chain_stat[TABLE_ENTRIES].found;
   assign rsp_chan.match_index = INDEX_OUT_W'(chain_idx[TABLE_ENTRIES]);
   assign rsp_chan.stored      = chain_stat[TABLE_ENTRIES].stored;
   assign rsp_chan.table_full  = chain_stat[TABLE_ENTRIES].full;
   assign rsp_chan.entry_total = TOTAL_OUT_W'(chain_total[TABLE_ENTRIES]);

   // count never passes capacity
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count above capacity");

   // a stored insert bumps the count by one
   a_held_step: assert property (@(posedge clock) disable iff (reset)
      req_xfer && chain_stat[0].stored |=> held_ff == $past(held_ff) + CNT_W'(1))
      else $error("entry count did not advance on insert");

   // a refused insert only happens with a full table
   a_full_cap: assert property (@(posedge clock) disable iff (reset)
      req_xfer && chain_stat[0].full |-> held_ff == CNT_W'(TABLE_ENTRIES))
      else $error("insert refused below capacity");

   // insert results never carry a hit, lookups never store
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.found |-> !rsp_chan.stored && !rsp_chan.table_full)
      else $error("lookup result carries insert flags");

   // a stalled result stays in place
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.match_index))
      else $error("stalled result changed");

endmodule

// ----- test/symbol_range_lookup_table_test.sv -----
`timescale 1ns / 100ps

module symbol_range_lookup_table_test;
   import srlt_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;
   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_CYCLES = TABLE_ENTRIES + 64;
   localparam int HOLD_CYCLES = 3 * TABLE_ENTRIES;
   localparam int TIMEOUT_NS = 2_000_000;
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;
   localparam logic [ADDR_W-1:0] WINDOW_BASE = 64'h0000_0000_8000_0000;
   localparam int SENDER_IDLE_PCT [3] = '{14, 70, 0};
   localparam int RECEIVER_IDLE_PCT [3] = '{70, 14, 0};

   typedef struct packed {
      logic                 mode;
      logic [INFO_W-1:0]    symbol_info;
      logic [ADDR_W-1:0]    address;
      logic [ADDR_W-1:0]    symbol_size;
   } symbol_req_type;

   typedef struct packed {
      logic                   found;
      logic [INDEX_OUT_W-1:0] match_index;
      logic                   stored;
      logic                   table_full;
      logic [TOTAL_OUT_W-1:0] entry_total;
   } match_rsp_type;

   // own copy of the range table and the queue of predicted match results
   class range_scoreboard;
      logic [ADDR_W-1:0] range_base [TABLE_ENTRIES];
      logic [ADDR_W-1:0] range_size [TABLE_ENTRIES];
      int                entries_held;
      match_rsp_type     pending_matches [$];
      int                mismatches;

      function new();
         entries_held = 0;
         mismatches = 0;
      endfunction

      // update the table for an accepted item and queue its result
      function void note_request(symbol_req_type item);
         match_rsp_type    res;
         logic [ADDR_W:0]  range_end;
         res = '0;
         if (item.mode == MODE_INSERT) begin
            if (item.symbol_info == FUNC_SYMBOL_INFO) begin
               if (entries_held < TABLE_ENTRIES) begin
                  range_base[entries_held] = item.address;
                  range_size[entries_held] = item.symbol_size;
                  entries_held++;
                  res.stored = 1'b1;
               end else begin
                  res.table_full = 1'b1;
               end
            end
         end else begin
            // lowest entry wins, end taken in 65 bits so it never wraps
            for (int i = 0; i < entries_held; i++) begin
               range_end = {1'b0, range_base[i]} + {1'b0, range_size[i]};
               if (item.address >= range_base[i] && {1'b0, item.address} < range_end) begin
                  res.found = 1'b1;
                  res.match_index = i[INDEX_OUT_W-1:0];
                  break;
               end
            end
         end
         res.entry_total = entries_held[TOTAL_OUT_W-1:0];
         pending_matches.push_back(res);
      endfunction

      // compare a result transfer with the oldest prediction
      function void check_response(match_rsp_type got);
         match_rsp_type want;
         if (pending_matches.size() == 0) begin
            $error("result transfer with no prediction waiting");
            mismatches++;
            return;
         end
         want = pending_matches.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            mismatches++;
         end
         if (got.match_index !== want.match_index) begin
            $error("match_index: expected %0d, actual %0d", want.match_index, got.match_index);
            mismatches++;
         end
         if (got.stored !== want.stored) begin
            $error("stored: expected %0d, actual %0d", want.stored, got.stored);
            mismatches++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, actual %0d", want.table_full, got.table_full);
            mismatches++;
         end
         if (got.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, actual %0d", want.entry_total, got.entry_total);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   srlt_req_if req_chan ();
   srlt_rsp_if rsp_chan ();

   symbol_range_lookup_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   range_scoreboard board;
   int              idle_phase;
   bit              hold_request;

   // clock
   initial begin
      board = new();
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic symbol_req_type make_req(logic mode, logic [INFO_W-1:0] info,
                                               logic [ADDR_W-1:0] addr,
                                               logic [ADDR_W-1:0] size);
      symbol_req_type item;
      item.mode = mode;
      item.symbol_info = info;
      item.address = addr;
      item.symbol_size = size;
      return item;
   endfunction

   // random item: mostly function inserts and lookups aimed at held ranges
   function automatic symbol_req_type make_random_item();
      symbol_req_type    item;
      int                pick;
      int                slot;
      logic [ADDR_W-1:0] offset;
      item.mode = MODE_LOOKUP;
      item.symbol_info = INFO_W'($urandom_range(255));
      item.address = {$urandom, $urandom};
      item.symbol_size = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 45) begin
         item.mode = MODE_INSERT;
         item.symbol_info = FUNC_SYMBOL_INFO;
         case ($urandom_range(3))
            0, 1: begin
               item.address = WINDOW_BASE + ADDR_W'($urandom_range(16'hffff));
               item.symbol_size = ADDR_W'($urandom_range(1024));
            end
            2: item.symbol_size = ADDR_W'($urandom_range(4096));
            default: ;
         endcase
      end else if (pick < 55) begin
         // random info byte, almost never a function
         item.mode = MODE_INSERT;
      end else begin
         case ($urandom_range(4))
            0, 1, 2: if (board.entries_held > 0) begin
               slot = $urandom_range(board.entries_held - 1);
               case ($urandom_range(3))
                  0: item.address = board.range_base[slot];
                  1: item.address = board.range_base[slot] + board.range_size[slot] - 1;
                  2: item.address = board.range_base[slot] + board.range_size[slot];
                  default: begin
                     offset = {$urandom, $urandom};
                     if (board.range_size[slot] != 0)
                        offset = offset % board.range_size[slot];
                     item.address = board.range_base[slot] + offset;
                  end
               endcase
            end
            3: item.address = WINDOW_BASE + ADDR_W'($urandom_range(20'hfffff));
            default: ;
         endcase
      end
      return item;
   endfunction

   // idle at random, then offer one item and wait for its transfer
   task automatic drive_symbol_req(symbol_req_type item);
      while ($urandom_range(99) < SENDER_IDLE_PCT[idle_phase]) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= item.mode;
      req_chan.symbol_info <= item.symbol_info;
      req_chan.address <= item.address;
      req_chan.symbol_size <= item.symbol_size;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_request(item);
   endtask

   // result side: check transfers, drive ready
   initial begin
      int            hold_left;
      match_rsp_type got;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.found = rsp_chan.found;
            got.match_index = rsp_chan.match_index;
            got.stored = rsp_chan.stored;
            got.table_full = rsp_chan.table_full;
            got.entry_total = rsp_chan.entry_total;
            board.check_response(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         // long hold-off so the chain fills and input ready drops
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= RECEIVER_IDLE_PCT[idle_phase]);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int             counted;
      symbol_req_type item;
      idle_phase = 0;
      hold_request = 1'b0;
      counted = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.mode <= MODE_INSERT;
      req_chan.symbol_info <= '0;
      req_chan.address <= '0;
      req_chan.symbol_size <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // lookups on the empty table
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, '0, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'hff, ALL_ONES, ALL_ONES));
      // non-function symbols are dropped
      drive_symbol_req(make_req(MODE_INSERT, 8'h00, {$urandom, $urandom}, {$urandom, $urandom}));
      drive_symbol_req(make_req(MODE_INSERT, 8'hff, ALL_ONES, ALL_ONES));
      drive_symbol_req(make_req(MODE_INSERT, FUNC_SYMBOL_INFO - 8'd1, 64'h1000, 64'h100));
      drive_symbol_req(make_req(MODE_INSERT, FUNC_SYMBOL_INFO + 8'd1, 64'h1000, 64'h100));
      // zero size, plain, wrapping end, overlap, near full span
      drive_symbol_req(make_req(MODE_INSERT, FUNC_SYMBOL_INFO, '0, '0));
      drive_symbol_req(make_req(MODE_INSERT, FUNC_SYMBOL_INFO, 64'h1000, 64'h100));
      drive_symbol_req(make_req(MODE_INSERT, FUNC_SYMBOL_INFO, ALL_ONES - 64'hf, ALL_ONES));
      drive_symbol_req(make_req(MODE_INSERT, FUNC_SYMBOL_INFO, 64'h1080, 64'h100));
      drive_symbol_req(make_req(MODE_INSERT, FUNC_SYMBOL_INFO, '0, ALL_ONES));
      // range edges and lowest index priority
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, '0, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, 64'h0fff, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, 64'h1000, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, 64'h10ff, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, 64'h1100, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, 64'h117f, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, 64'h1180, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, ALL_ONES - 64'h10, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, ALL_ONES - 64'hf, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, 8'h00, ALL_ONES, '0));
      drive_symbol_req(make_req(MODE_LOOKUP, FUNC_SYMBOL_INFO, 64'h1000, ALL_ONES));

      // random part in three idling phases, hold-off at the start of the last
      while (counted < RANDOM_ITEMS) begin
         if (counted * 3 / RANDOM_ITEMS != idle_phase) begin
            idle_phase = counted * 3 / RANDOM_ITEMS;
            if (idle_phase == 2)
               hold_request = 1'b1;
         end
         item = make_random_item();
         drive_symbol_req(item);
         counted++;
      end
      req_chan.valid <= 1'b0;

      // drain, then watch for stray results
      while (board.pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
